>>> rtl/adcss_pkg.sv
// Package: shared types, constants and helpers of the ADC scan sequencer.
`timescale 1ns / 1ps

package adcss_pkg;

    localparam int MAX_CHAIN    = 8;
    localparam int CHANNEL_BITS = 5;

    localparam int CMD_W   = 2;
    localparam int MUX_W   = 5;
    localparam int SAMPLE_W = 8;
    localparam int RIDX_W  = 3;
    localparam int LEN_W   = 4;
    localparam int SCAN_W  = 40;
    localparam int IDX_W   = 4;
    localparam int LATCH_W = $clog2(MAX_CHAIN + 1);
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_SINGLE = 2'd0,
        CMD_CHAIN  = 2'd1,
        CMD_DONE   = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    localparam logic [CFG_IDX_W-1:0] REG_CHAIN_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_CHANNELS = 2'd1;

    typedef struct packed {
        logic [LEN_W-1:0]  chain_length;
        logic [SCAN_W-1:0] scan_channels;
    } cfg_t;

    typedef struct packed {
        cmd_t                command;
        logic [MUX_W-1:0]    channel;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        status_t             status;
        logic [MUX_W-1:0]    mux_select;
        logic                start_pulse;
        logic                irq_enable;
        logic                result_valid;
        logic [RIDX_W-1:0]   result_index;
        logic [SAMPLE_W-1:0] result_value;
        logic                done_res;
    } result_t;

    localparam logic [MUX_W-1:0] CHAN_MASK = MUX_W'((1 << CHANNEL_BITS) - 1);

    function automatic logic [MUX_W-1:0] list_entry(
        input logic [SCAN_W-1:0] scan,
        input logic [IDX_W-1:0]  idx
    );
        logic [SCAN_W-1:0] shifted;
        logic [7:0]        wide;
        int                shift;
        shift   = int'(idx) * CHANNEL_BITS;
        shifted = scan >> shift;
        wide    = 8'(shifted[CHANNEL_BITS-1:0]);
        if (shift >= SCAN_W) begin
            return '0;
        end
        return wide[MUX_W-1:0];
    endfunction

    function automatic logic [LATCH_W-1:0] effective_length(input logic [LEN_W-1:0] n);
        if (n == '0) begin
            return LATCH_W'(1);
        end
        if (int'(n) > MAX_CHAIN) begin
            return LATCH_W'(MAX_CHAIN);
        end
        return LATCH_W'(n);
    endfunction

endpackage

>>> rtl/adc_scan_sequencer_core.sv
// Top level of the ADC scan sequencer.
// Takes one command transaction per clock while s_tready is high (start single,
// start chain, conversion complete) and returns exactly one result transaction for
// each. The state update and result selection for a transaction complete in the
// cycle it is accepted; a two-entry output buffer decouples s_tready from m_tready,
// so s_tready falls only once two results are waiting. Configuration writes are
// always accepted (cfg_ready is tied high); the chain length is latched when a
// chain starts, while channel numbers are read from the list at each start.
`timescale 1ns / 1ps

module adc_scan_sequencer_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,   // channel[4:0], sample[12:5]
    input  logic [1:0]                         s_tuser,   // command[1:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [23:0]                        m_tdata,   // mux_select[4:0],
                                                          // start_pulse[5],
                                                          // irq_enable[6],
                                                          // result_valid[7],
                                                          // result_index[10:8],
                                                          // result_value[18:11]
    output logic [1:0]                         m_tuser,   // status[1:0]
    output logic                               m_tlast,   // done_res
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [adcss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [adcss_pkg::SCAN_W-1:0]       cfg_data
);

    adcss_pkg::cfg_t     cfg;
    adcss_pkg::item_t    item;
    adcss_pkg::result_t  step_result;
    adcss_pkg::result_t  out_result;
    logic                accept;

    assign cfg_ready    = 1'b1;
    assign item.command = adcss_pkg::cmd_t'(s_tuser);
    assign item.channel = s_tdata[4:0];
    assign item.sample  = s_tdata[12:5];
    assign accept       = s_tvalid && s_tready;

    adcss_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    adcss_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (item),
        .cfg     (cfg),
        .result  (step_result)
    );

    adcss_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (step_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {5'd0,
                      out_result.result_value,
                      out_result.result_index,
                      out_result.result_valid,
                      out_result.irq_enable,
                      out_result.start_pulse,
                      out_result.mux_select};
    assign m_tuser = out_result.status;
    assign m_tlast = out_result.done_res;

endmodule

>>> rtl/adcss_cfg_regs.sv
// Configuration registers: chain length and packed scan channel list.
`timescale 1ns / 1ps

module adcss_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [adcss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [adcss_pkg::SCAN_W-1:0]       cfg_data,
    output adcss_pkg::cfg_t                    cfg
);

    adcss_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.chain_length  <= adcss_pkg::LEN_W'(1);
            cfg_reg.scan_channels <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == adcss_pkg::REG_CHAIN_LENGTH) begin
                cfg_reg.chain_length <= cfg_data[adcss_pkg::LEN_W-1:0];
            end else if (cfg_index == adcss_pkg::REG_SCAN_CHANNELS) begin
                cfg_reg.scan_channels <= cfg_data;
            end
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/adcss_step.sv
// Sequencer state and the per-transaction step logic.
`timescale 1ns / 1ps

module adcss_step (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  adcss_pkg::item_t     item,
    input  adcss_pkg::cfg_t      cfg,
    output adcss_pkg::result_t   result
);

    logic                                busy_reg, busy_next;
    logic                                chain_mode_reg, chain_mode_next;
    logic [adcss_pkg::IDX_W-1:0]         scan_index_reg, scan_index_next;
    logic [adcss_pkg::MUX_W-1:0]         mux_hold_reg, mux_hold_next;
    logic [adcss_pkg::LATCH_W-1:0]       len_latched_reg, len_latched_next;
    logic [adcss_pkg::IDX_W-1:0]         index_inc;

    always_comb begin
        busy_next        = busy_reg;
        chain_mode_next  = chain_mode_reg;
        scan_index_next  = scan_index_reg;
        mux_hold_next    = mux_hold_reg;
        len_latched_next = len_latched_reg;
        index_inc        = scan_index_reg + 1'b1;

        result.status       = adcss_pkg::ST_OK;
        result.start_pulse  = 1'b0;
        result.result_valid = 1'b0;
        result.result_index = '0;
        result.result_value = '0;
        result.done_res     = 1'b0;

        case (item.command)
            adcss_pkg::CMD_SINGLE, adcss_pkg::CMD_CHAIN: begin
                if (busy_reg) begin
                    result.status = adcss_pkg::ST_BUSY;
                end else begin
                    busy_next          = 1'b1;
                    result.start_pulse = 1'b1;
                    if (item.command == adcss_pkg::CMD_SINGLE) begin
                        chain_mode_next = 1'b0;
                        mux_hold_next   = item.channel & adcss_pkg::CHAN_MASK;
                    end else begin
                        chain_mode_next  = 1'b1;
                        scan_index_next  = '0;
                        len_latched_next = adcss_pkg::effective_length(cfg.chain_length);
                        mux_hold_next    = adcss_pkg::list_entry(cfg.scan_channels, '0);
                    end
                end
            end
            adcss_pkg::CMD_DONE: begin
                if (busy_reg) begin
                    result.result_valid = 1'b1;
                    result.result_value = item.sample;
                    if (!chain_mode_reg) begin
                        busy_next       = 1'b0;
                        result.done_res = 1'b1;
                    end else begin
                        result.result_index = scan_index_reg[adcss_pkg::RIDX_W-1:0];
                        scan_index_next     = index_inc;
                        if (adcss_pkg::LATCH_W'(index_inc) >= len_latched_reg) begin
                            busy_next       = 1'b0;
                            result.done_res = 1'b1;
                        end else begin
                            mux_hold_next = adcss_pkg::list_entry(cfg.scan_channels,
                                                                  index_inc);
                            result.start_pulse = 1'b1;
                        end
                    end
                end else begin
                    result.status = adcss_pkg::ST_IGNORED;
                end
            end
            default: begin
                result.status = adcss_pkg::ST_IGNORED;
            end
        endcase

        result.mux_select = mux_hold_next;
        result.irq_enable = busy_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            chain_mode_reg  <= 1'b0;
            scan_index_reg  <= '0;
            mux_hold_reg    <= '0;
            len_latched_reg <= adcss_pkg::LATCH_W'(1);
        end else if (accept) begin
            busy_reg        <= busy_next;
            chain_mode_reg  <= chain_mode_next;
            scan_index_reg  <= scan_index_next;
            mux_hold_reg    <= mux_hold_next;
            len_latched_reg <= len_latched_next;
        end
    end

endmodule

>>> rtl/adcss_out_buf.sv
// Two-entry output buffer: result register plus skid register.
`timescale 1ns / 1ps

module adcss_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  adcss_pkg::result_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output adcss_pkg::result_t   out_data
);

    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    adcss_pkg::result_t  out_reg, out_next;
    adcss_pkg::result_t  skid_reg, skid_next;
    logic                push, pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb begin
        push            = in_valid && !skid_valid_reg;
        pop             = out_valid_reg && out_ready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else if (push) begin
                out_next = in_data;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg) begin
                skid_next       = in_data;
                skid_valid_next = 1'b1;
            end else begin
                out_next       = in_data;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule
